// ===== rtl/rbv_pkg.sv =====
package rbv_pkg;

	localparam int unsigned POS_W = 33;

	// fixed header layout
	localparam logic [POS_W-1:0] HDR_BYTES    = 33'd52;
	localparam logic [POS_W-1:0] PREFIX_BYTES = 33'd12;
	localparam logic [POS_W-1:0] OFS_LENGTH   = 33'd8;
	localparam logic [POS_W-1:0] OFS_CRC      = 33'd12;
	localparam logic [POS_W-1:0] OFS_CRC_END  = 33'd16;
	localparam logic [POS_W-1:0] OFS_MAGIC    = 33'd20;
	localparam logic [POS_W-1:0] OFS_ATTR     = 33'd21;
	localparam logic [POS_W-1:0] OFS_DELTA    = 33'd22;
	localparam logic [POS_W-1:0] OFS_DELTA_END = 33'd26;
	localparam logic [POS_W-1:0] OFS_COUNT    = 33'd48;
	localparam logic [POS_W-1:0] POS_MAX      = '1;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

	// configuration register indexes
	localparam logic [1:0] CFG_MAGIC      = 2'd0;
	localparam logic [1:0] CFG_COMP_MASK  = 2'd1;
	localparam logic [1:0] CFG_MAX_BYTES  = 2'd2;
	localparam logic [1:0] CFG_CRC_START  = 2'd3;

	// verdict codes
	localparam logic [3:0] FAIL_NONE      = 4'd0;
	localparam logic [3:0] FAIL_SHORT     = 4'd1;
	localparam logic [3:0] FAIL_MAGIC     = 4'd2;
	localparam logic [3:0] FAIL_RANGE     = 4'd3;
	localparam logic [3:0] FAIL_TRUNC     = 4'd4;
	localparam logic [3:0] FAIL_CRC       = 4'd5;
	localparam logic [3:0] FAIL_ZERO_RECS = 4'd6;
	localparam logic [3:0] FAIL_DELTA     = 4'd7;
	localparam logic [3:0] FAIL_COMPRESS  = 4'd8;
	localparam logic [3:0] FAIL_STRUCT    = 4'd9;

	// reflected CRC-32C, one byte
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/record_batch_validator_top.sv =====
// Record batch validator. Bytes of one framed batch enter one per item on the
// in channel, the final byte flagged by last; that byte yields one verdict on
// the out channel (batch_ok, fail_reason) and clears the stream state, while
// the configuration registers keep their values. A byte sits in the input
// register, then the CRC-32C byte step, the header capture, the record walker
// and, on the last byte, the verdict all update together, so a byte is taken
// in every cycle unless the input side stalls. The verdict waits in an output
// register; the input side stalls only when a last byte finds that register
// still full. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce it.
module record_batch_validator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        batch_ok,
	output logic [3:0]  fail_reason,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [32:0] cfg_data
);

	// configuration
	logic [7:0]  magic_q;
	logic [7:0]  comp_mask_q;
	logic [32:0] max_bytes_q;
	logic [5:0]  crc_start_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// stream state
	logic [32:0] pos_q;
	logic [31:0] len_field_q, crc_field_q, delta_q, count_q;
	logic [7:0]  hdr_magic_q, attr_q;
	logic [31:0] crc_q, seen_q, acc_q, remain_q;
	logic [2:0]  idx_q;
	logic        bad_q;

	// output register
	logic        out_valid_q;
	logic        ok_q;
	logic [3:0]  reason_q;

	logic        go;

	assign go        = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || go;
	assign out_valid = out_valid_q;
	assign batch_ok  = ok_q;
	assign fail_reason = reason_q;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= 8'd0;
			comp_mask_q <= 8'd7;
			max_bytes_q <= 33'd1048576;
			crc_start_q <= 6'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				rbv_pkg::CFG_MAGIC:     magic_q     <= cfg_data[7:0];
				rbv_pkg::CFG_COMP_MASK: comp_mask_q <= cfg_data[7:0];
				rbv_pkg::CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				rbv_pkg::CFG_CRC_START: crc_start_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// next stream state
	logic [32:0] total_q;
	logic [32:0] pos_n;
	logic [31:0] len_field_n, crc_field_n, delta_n, count_n;
	logic [7:0]  hdr_magic_n, attr_n;
	logic [31:0] crc_n, seen_n, acc_n, remain_n, acc_v;
	logic [2:0]  idx_n;
	logic        bad_n;
	logic        do_crc, do_walk;
	logic [1:0]  lane, delta_lane;

	assign total_q    = {1'b0, len_field_q} + rbv_pkg::PREFIX_BYTES;
	assign lane       = pos_q[1:0];
	assign delta_lane = pos_q[1:0] - 2'd2;
	assign do_crc     = (pos_q >= {27'd0, crc_start_q}) &&
		((pos_q < rbv_pkg::PREFIX_BYTES) || (pos_q < total_q));
	assign do_walk    = (pos_q >= rbv_pkg::HDR_BYTES) && (pos_q < total_q);

	always_comb begin
		pos_n       = (pos_q != rbv_pkg::POS_MAX) ? pos_q + 33'd1 : pos_q;
		len_field_n = len_field_q;
		crc_field_n = crc_field_q;
		delta_n     = delta_q;
		count_n     = count_q;
		hdr_magic_n = hdr_magic_q;
		attr_n      = attr_q;

		// capture header fields
		if (pos_q >= rbv_pkg::OFS_LENGTH && pos_q < rbv_pkg::OFS_CRC) begin
			len_field_n[{lane, 3'b000} +: 8] = byte_s1;
		end else if (pos_q >= rbv_pkg::OFS_CRC && pos_q < rbv_pkg::OFS_CRC_END) begin
			crc_field_n[{lane, 3'b000} +: 8] = byte_s1;
		end else if (pos_q == rbv_pkg::OFS_MAGIC) begin
			hdr_magic_n = byte_s1;
		end else if (pos_q == rbv_pkg::OFS_ATTR) begin
			attr_n = byte_s1;
		end else if (pos_q >= rbv_pkg::OFS_DELTA && pos_q < rbv_pkg::OFS_DELTA_END) begin
			delta_n[{delta_lane, 3'b000} +: 8] = byte_s1;
		end else if (pos_q >= rbv_pkg::OFS_COUNT && pos_q < rbv_pkg::HDR_BYTES) begin
			count_n[{lane, 3'b000} +: 8] = byte_s1;
		end

		crc_n = do_crc ? rbv_pkg::crc32c_byte(crc_q, byte_s1) : crc_q;

		// walk length-prefixed records
		bad_n    = bad_q;
		remain_n = remain_q;
		seen_n   = seen_q;
		acc_n    = acc_q;
		idx_n    = idx_q;
		acc_v    = acc_q | ({24'd0, byte_s1} << {idx_q[1:0], 3'b000});
		if (do_walk && !bad_q) begin
			if (remain_q != 32'd0) begin
				remain_n = remain_q - 32'd1;
				if (remain_q == 32'd1) begin
					seen_n = seen_q + 32'd1;
				end
			end else if (seen_q == count_q) begin
				bad_n = 1'b1;
			end else if (idx_q >= 3'd3) begin
				idx_n = 3'd0;
				acc_n = 32'd0;
				if (acc_v == 32'd0) begin
					seen_n = seen_q + 32'd1;
				end else begin
					remain_n = acc_v;
				end
			end else begin
				idx_n = idx_q + 3'd1;
				acc_n = acc_v;
			end
		end
	end

	// verdict on the updated state
	logic [32:0] total_n;
	logic [3:0]  reason_n;

	assign total_n = {1'b0, len_field_n} + rbv_pkg::PREFIX_BYTES;

	always_comb begin
		if (pos_n < rbv_pkg::HDR_BYTES) begin
			reason_n = rbv_pkg::FAIL_SHORT;
		end else if (hdr_magic_n != magic_q) begin
			reason_n = rbv_pkg::FAIL_MAGIC;
		end else if (total_n < rbv_pkg::HDR_BYTES || total_n > max_bytes_q) begin
			reason_n = rbv_pkg::FAIL_RANGE;
		end else if (pos_n < total_n) begin
			reason_n = rbv_pkg::FAIL_TRUNC;
		end else if (~crc_n != crc_field_n) begin
			reason_n = rbv_pkg::FAIL_CRC;
		end else if (count_n == 32'd0) begin
			reason_n = rbv_pkg::FAIL_ZERO_RECS;
		end else if (delta_n != count_n - 32'd1) begin
			reason_n = rbv_pkg::FAIL_DELTA;
		end else if ((attr_n & comp_mask_q) != 8'd0) begin
			reason_n = rbv_pkg::FAIL_COMPRESS;
		end else if (bad_n || seen_n != count_n || remain_n != 32'd0 || idx_n != 3'd0) begin
			reason_n = rbv_pkg::FAIL_STRUCT;
		end else begin
			reason_n = rbv_pkg::FAIL_NONE;
		end
	end

	// advance stream state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			len_field_q <= '0;
			crc_field_q <= '0;
			delta_q     <= '0;
			count_q     <= '0;
			hdr_magic_q <= '0;
			attr_q      <= '0;
			crc_q       <= '1;
			seen_q      <= '0;
			acc_q       <= '0;
			remain_q    <= '0;
			idx_q       <= '0;
			bad_q       <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				pos_q       <= '0;
				len_field_q <= '0;
				crc_field_q <= '0;
				delta_q     <= '0;
				count_q     <= '0;
				hdr_magic_q <= '0;
				attr_q      <= '0;
				crc_q       <= '1;
				seen_q      <= '0;
				acc_q       <= '0;
				remain_q    <= '0;
				idx_q       <= '0;
				bad_q       <= 1'b0;
			end else begin
				pos_q       <= pos_n;
				len_field_q <= len_field_n;
				crc_field_q <= crc_field_n;
				delta_q     <= delta_n;
				count_q     <= count_n;
				hdr_magic_q <= hdr_magic_n;
				attr_q      <= attr_n;
				crc_q       <= crc_n;
				seen_q      <= seen_n;
				acc_q       <= acc_n;
				remain_q    <= remain_n;
				idx_q       <= idx_n;
				bad_q       <= bad_n;
			end
		end
	end

	// load the verdict; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			ok_q     <= (reason_n == rbv_pkg::FAIL_NONE);
			reason_q <= reason_n;
		end
	end

`ifndef SYNTH
	a_ok_means_no_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> reason_q == rbv_pkg::FAIL_NONE)
		else $error("pass verdict carries a fail reason");

	a_last_clears_stream: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> pos_q == '0 && crc_q == '1 && !bad_q && idx_q == 3'd0)
		else $error("stream state not cleared after last byte");

	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		go && last_s1 |=> out_valid_q)
		else $error("last byte produced no verdict");

	a_byte_counts: assert property (@(posedge clk) disable iff (!arst_n)
		go && !last_s1 |=> pos_q != '0)
		else $error("byte position did not advance");

	a_stall_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("last byte retired over an unread verdict");
`endif

endmodule

// ===== dv/record_batch_validator_top_tb.sv =====
`timescale 1ns / 1ps

module record_batch_validator_top_tb;

	localparam logic [32:0] MAX_TOTAL = 33'h1_0000_000B;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	// ways to shape or damage a generated batch
	typedef enum int {
		MK_GOOD, MK_TAIL, MK_MAGIC, MK_RANGE, MK_LONGLEN, MK_TRUNC, MK_CRC, MK_ZERO,
		MK_DELTA, MK_COMP, MK_EXTRA, MK_CNT_HI, MK_CNT_LO, MK_CUT, MK_PREFIX, MK_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] reason;
	} verdict_t;

	typedef struct packed {
		logic [32:0] pos;
		logic [31:0] len_f;
		logic [31:0] crc_f;
		logic [7:0]  magic;
		logic [7:0]  attr;
		logic [31:0] delta;
		logic [31:0] count;
		logic [31:0] crc;
		logic [31:0] recs;
		logic [31:0] len_acc;
		logic [2:0]  len_idx;
		logic [31:0] pay_left;
		logic        bad;
	} stream_state_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        batch_ok;
	logic [3:0]  fail_reason;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = rbv_pkg::CFG_MAGIC;
	logic [32:0] cfg_data = 33'd0;

	// register copies, at their reset values
	logic [7:0]  cfg_magic = 8'd0;
	logic [7:0]  cfg_cmask = 8'd7;
	logic [32:0] cfg_max = 33'd1048576;
	logic [5:0]  cfg_crc_start = 6'd16;

	stream_state_t strm;
	byte_item_t    pend_q[$];
	verdict_t      verdict_q[$];
	logic [7:0]    frame[$];

	int errors = 0;
	int mismatches = 0;
	int cycles = 0;
	int bytes_in = 0;
	int frames_sent = 0;
	int verdicts_seen = 0;
	int in_stall_cycles = 0;
	int reason_hits[16];
	int burst_left = 1;
	int gap_left = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int pat_left = 0;
	int pat_mode = 0;
	logic [31:0] pat = '0;

	record_batch_validator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.batch_ok(batch_ok),
		.fail_reason(fail_reason),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// reflected CRC-32C, one byte
	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'd0, b};
		repeat (8) r = (r >> 1) ^ (rbv_pkg::CRC_POLY & {32{r[0]}});
		return r;
	endfunction

	// advance the stream state by one byte; on the final byte queue the verdict
	function automatic void predict_verdict(input logic [7:0] b, input logic fin);
		logic [32:0] p;
		logic [32:0] total;
		logic [3:0]  why;
		verdict_t    v;
		p = strm.pos;
		total = rbv_pkg::PREFIX_BYTES + {1'b0, strm.len_f};

		// capture header fields
		if (p >= rbv_pkg::OFS_LENGTH && p < rbv_pkg::OFS_CRC)
			strm.len_f[8 * int'(p - rbv_pkg::OFS_LENGTH) +: 8] = b;
		else if (p >= rbv_pkg::OFS_CRC && p < rbv_pkg::OFS_CRC_END)
			strm.crc_f[8 * int'(p - rbv_pkg::OFS_CRC) +: 8] = b;
		else if (p == rbv_pkg::OFS_MAGIC)
			strm.magic = b;
		else if (p == rbv_pkg::OFS_ATTR)
			strm.attr = b;
		else if (p >= rbv_pkg::OFS_DELTA && p < rbv_pkg::OFS_DELTA_END)
			strm.delta[8 * int'(p - rbv_pkg::OFS_DELTA) +: 8] = b;
		else if (p >= rbv_pkg::OFS_COUNT && p < rbv_pkg::HDR_BYTES)
			strm.count[8 * int'(p - rbv_pkg::OFS_COUNT) +: 8] = b;

		if (p >= {27'd0, cfg_crc_start} && (p < rbv_pkg::PREFIX_BYTES || p < total))
			strm.crc = crc_step(strm.crc, b);

		// walk length-prefixed records inside the batch
		if (p >= rbv_pkg::HDR_BYTES && p < total && !strm.bad) begin
			if (strm.pay_left != 0) begin
				strm.pay_left--;
				if (strm.pay_left == 0)
					strm.recs++;
			end else if (strm.recs == strm.count) begin
				strm.bad = 1'b1;
			end else begin
				strm.len_acc = strm.len_acc | ({24'd0, b} << (8 * strm.len_idx[1:0]));
				if (strm.len_idx >= 3'd3) begin
					strm.len_idx = '0;
					if (strm.len_acc == 0)
						strm.recs++;
					else
						strm.pay_left = strm.len_acc;
					strm.len_acc = '0;
				end else begin
					strm.len_idx++;
				end
			end
		end

		if (strm.pos != rbv_pkg::POS_MAX)
			strm.pos++;

		if (fin) begin
			total = rbv_pkg::PREFIX_BYTES + {1'b0, strm.len_f};
			if (strm.pos < rbv_pkg::HDR_BYTES)
				why = rbv_pkg::FAIL_SHORT;
			else if (strm.magic != cfg_magic)
				why = rbv_pkg::FAIL_MAGIC;
			else if (total < rbv_pkg::HDR_BYTES || total > cfg_max)
				why = rbv_pkg::FAIL_RANGE;
			else if (strm.pos < total)
				why = rbv_pkg::FAIL_TRUNC;
			else if ((strm.crc ^ 32'hFFFF_FFFF) != strm.crc_f)
				why = rbv_pkg::FAIL_CRC;
			else if (strm.count == 0)
				why = rbv_pkg::FAIL_ZERO_RECS;
			else if (strm.delta != strm.count - 32'd1)
				why = rbv_pkg::FAIL_DELTA;
			else if ((strm.attr & cfg_cmask) != 0)
				why = rbv_pkg::FAIL_COMPRESS;
			else if (strm.bad || strm.recs != strm.count || strm.pay_left != 0 ||
				 strm.len_idx != 0)
				why = rbv_pkg::FAIL_STRUCT;
			else
				why = rbv_pkg::FAIL_NONE;
			v.ok = (why == rbv_pkg::FAIL_NONE);
			v.reason = why;
			verdict_q.push_back(v);
			reason_hits[why]++;
			strm = '0;
			strm.crc = '1;
		end
	endfunction

	function automatic void put_le32(input int at, input logic [31:0] val);
		for (int i = 0; i < 4; i++)
			frame[at + i] = val[8 * i +: 8];
	endfunction

	// build one framed batch in the frame buffer under the current registers
	task automatic build_frame(input frame_kind_t kind, input int n_recs);
		int recs;
		int rl;
		int lo;
		int cut;
		logic [31:0] cnt;
		logic [31:0] dlt;
		logic [31:0] len;
		logic [31:0] crc;
		logic [7:0]  attr;
		longint unsigned tot;
		frame.delete();
		if (kind == MK_NOISE) begin
			repeat ($urandom_range(1, 80)) frame.push_back(8'($urandom));
			return;
		end

		recs = (kind == MK_ZERO) ? 0 : n_recs;
		repeat (52) frame.push_back(8'($urandom));
		for (int i = 0; i < recs; i++) begin
			rl = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
			repeat (4) frame.push_back(8'h00);
			put_le32(frame.size() - 4, rl);
			repeat (rl) frame.push_back(8'($urandom));
		end
		cnt = recs;

		// break the record layout
		case (kind)
			MK_EXTRA: repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
			MK_CNT_HI: cnt = recs + 1;
			MK_CNT_LO: cnt = recs - 1;
			MK_CUT: begin
				repeat ($urandom_range(1, 3))
					if (frame.size() > 52)
						void'(frame.pop_back());
			end
			MK_PREFIX: begin
				repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
				cnt = recs + 1;
			end
			default: ;
		endcase

		len = frame.size() - 12;
		if (kind == MK_RANGE) begin
			if ($urandom_range(0, 1) == 1 && cfg_max < MAX_TOTAL)
				len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'(cfg_max - 33'd11);
			else
				len = $urandom_range(0, 39);
		end else if (kind == MK_LONGLEN) begin
			len = 32'hFFFF_FFFF - $urandom_range(0, 1000);
		end
		put_le32(8, len);

		frame[20] = (kind == MK_MAGIC) ? cfg_magic ^ 8'($urandom_range(1, 255)) : cfg_magic;
		attr = 8'($urandom) & ~cfg_cmask;
		if (kind == MK_COMP)
			attr = attr | (cfg_cmask & 8'($urandom_range(1, 255)));
		frame[21] = attr;
		dlt = (kind == MK_ZERO && $urandom_range(0, 1) == 1) ? $urandom : cnt - 1;
		if (kind == MK_DELTA)
			dlt = dlt ^ (32'd1 << $urandom_range(0, 31));
		put_le32(22, dlt);
		put_le32(48, cnt);

		// seal with the CRC over the covered range
		tot = 64'(len) + 64'd12;
		crc = '1;
		for (int p = cfg_crc_start; p < frame.size() && (p < 12 || p < tot); p++)
			crc = crc_step(crc, frame[p]);
		put_le32(12, ~crc);

		if (kind == MK_CRC) begin
			lo = (cfg_crc_start > 26) ? cfg_crc_start : 26;
			if (lo < frame.size() && $urandom_range(0, 1) == 1)
				frame[$urandom_range(lo, frame.size() - 1)] ^= 8'd1 << $urandom_range(0, 7);
			else
				frame[12 + $urandom_range(0, 3)] ^= 8'd1 << $urandom_range(0, 7);
		end
		if (kind == MK_TAIL)
			repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
		if (kind == MK_TRUNC) begin
			cut = $urandom_range(1, frame.size() - 1);
			frame = frame[0:cut - 1];
		end
	endtask

	task automatic push_frame();
		foreach (frame[i])
			pend_q.push_back('{data: frame[i], fin: (i == frame.size() - 1)});
		frames_sent++;
	endtask

	// hold off until every byte is in and every verdict is out, then let the pipe settle
	task automatic wait_idle();
		do @(negedge clk);
		while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] magic, input logic [7:0] cmask,
				  input logic [32:0] max_bytes, input logic [5:0] crc_start);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rbv_pkg::CFG_MAGIC;
		cfg_data <= {25'd0, magic};
		@(posedge clk);
		cfg_index <= rbv_pkg::CFG_COMP_MASK;
		cfg_data <= {25'd0, cmask};
		@(posedge clk);
		cfg_index <= rbv_pkg::CFG_MAX_BYTES;
		cfg_data <= max_bytes;
		@(posedge clk);
		cfg_index <= rbv_pkg::CFG_CRC_START;
		cfg_data <= {27'd0, crc_start};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_magic = magic;
		cfg_cmask = cmask;
		cfg_max = max_bytes;
		cfg_crc_start = crc_start;
		@(negedge clk);
	endtask

	// one batch of each kind in a range, random content, then drain
	task automatic sweep(input frame_kind_t first_k, input frame_kind_t last_k);
		for (int k = first_k; k <= last_k; k++) begin
			build_frame(frame_kind_t'(k), 1);
			push_frame();
		end
		wait_idle();
	endtask

	// send items in bursts, predict each accepted byte
	always @(posedge clk or negedge arst_n) begin
		byte_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
			strm = '0;
			strm.crc = '1;
		end else begin
			if (in_valid && in_ready) begin
				predict_verdict(data_byte, last);
				bytes_in++;
			end
			if (in_valid && !in_ready) begin
				in_stall_cycles++;
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				nxt = pend_q.pop_front();
				data_byte <= nxt.data;
				last <= nxt.fin;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					burst_left = $urandom_range(1, 48);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// stall the output on a pattern of its own, plus one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat = $urandom;
				pat_mode = $urandom_range(0, 2);
				pat_left = 32;
			end
			pat_left--;
			case (pat_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= pat[pat_left];
				default: out_ready <= pat[pat_left] | pat[31 - pat_left];
			endcase
		end
	end

	// compare each verdict with the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict ok=%0d reason=%0d", batch_ok, fail_reason);
			end else begin
				want = verdict_q.pop_front();
				if (batch_ok !== want.ok || fail_reason !== want.reason) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("verdict %0d: expected ok=%0d reason=%0d, got ok=%0d reason=%0d",
							 verdicts_seen, want.ok, want.reason, batch_ok, fail_reason);
				end
				verdicts_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding",
				 cycles, verdict_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		string tally;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers, header edge lengths, then the first kinds
		frame = '{8'hFF};
		push_frame();
		build_frame(MK_GOOD, 1);
		frame = frame[0:50];
		push_frame();
		build_frame(MK_GOOD, 1);
		frame = frame[0:51];
		push_frame();
		sweep(MK_GOOD, MK_TRUNC);

		// spread the remaining kinds over other register settings
		set_config(8'h02, 8'h07, 33'd1048576, 6'd21);
		sweep(MK_CRC, MK_COMP);
		set_config(8'hFF, 8'hFF, MAX_TOTAL, 6'd16);
		sweep(MK_EXTRA, MK_PREFIX);
		set_config(8'h00, 8'h00, 33'd52, 6'd52);
		sweep(MK_NOISE, MK_NOISE);
		set_config(8'h5A, 8'h80, 33'd4096, 6'd0);
		sweep(MK_GOOD, MK_GOOD);
		set_config(8'h02, 8'h07, 33'd1048576, 6'd63);

		// long output hold while short buffers keep coming
		hold_req++;
		repeat (20) begin
			frame.delete();
			repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
			push_frame();
		end
		wait_idle();

		if (verdict_q.size() != 0)
			errors++;
		tally = "";
		for (int r = 0; r < 10; r++)
			tally = {tally, $sformatf(" %0d:%0d", r, reason_hits[r])};
		$display("%0d batches, %0d bytes, six register settings; input held %0d cycles",
			 frames_sent, bytes_in, in_stall_cycles);
		$display("verdicts by reason code:%s", tally);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rbv_pkg.sv
rtl/record_batch_validator_top.sv
dv/record_batch_validator_top_tb.sv
